### src/pfru_pkg.sv
// Package for the pixel format to RGB24 unpacker.
// Holds format codes, register indexes, the row status struct and the field widen helpers.
// No dependencies.
`timescale 1ns / 1ps

package pfru_pkg;

   // Source pixel format codes; the two unused codes behave as rgb32
   typedef enum logic [2:0] {
      FMT_MONO     = 3'd0,
      FMT_GREY8    = 3'd1,
      FMT_RGB565   = 3'd2,
      FMT_ARGB1555 = 3'd3,
      FMT_RGB24    = 3'd4,
      FMT_RGB32    = 3'd5,
      FMT_SPARE6   = 3'd6,
      FMT_SPARE7   = 3'd7
   } pix_fmt_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_PIXEL_FORMAT = 2'd0,
      REG_ROW_PIXELS   = 2'd1,
      REG_ROW_COUNT    = 2'd2,
      REG_PAD_ENABLE   = 2'd3
   } csr_index_type;

   localparam int DIM_REG_W   = 13;
   localparam int BYTE_W      = 8;
   localparam int COLOR_W     = 24;
   localparam int RSP_DATA_W  = 32;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hff_ffff;

   // Row and picture position of the pixel about to be emitted
   typedef struct packed {
      logic       row_end;
      logic       picture_end;
      logic [1:0] pad_bytes;
   } pos_status_type;

   // 5-bit field to 8 bits, low bits set to ones when nonzero
   function automatic logic [7:0] widen5(input logic [4:0] field);
      logic [7:0] v;
      v = {field, 3'b000};
      if (field != 5'd0) begin
         v = v | 8'h07;
      end
      return v;
   endfunction

   // 6-bit field to 8 bits, low bits set to ones when nonzero
   function automatic logic [7:0] widen6(input logic [5:0] field);
      logic [7:0] v;
      v = {field, 2'b00};
      if (field != 6'd0) begin
         v = v | 8'h03;
      end
      return v;
   endfunction

endpackage

### src/pfru_color.sv
// Color conversion for the pixel format to RGB24 unpacker.
// Pure combinational: maps mono bits, grey bytes and gathered multi-byte words to RGB888.
// Depends on pfru_pkg.
`timescale 1ns / 1ps

module pfru_color (
   input  pfru_pkg::pix_fmt_type        fmt,
   input  logic [pfru_pkg::BYTE_W-1:0]  src_byte,
   input  logic [2:0]                   mono_bit,
   input  logic [pfru_pkg::COLOR_W-1:0] gathered,
   output logic [pfru_pkg::COLOR_W-1:0] color
);

   logic [15:0] word;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;

   assign word = gathered[15:0];

   // 16bpp field unpack, red always in bits 15:11
   always_comb begin
      blue = pfru_pkg::widen5(word[4:0]);
      red  = pfru_pkg::widen5(word[15:11]);
      if (fmt == pfru_pkg::FMT_RGB565) begin
         green = pfru_pkg::widen6(word[10:5]);
      end else begin
         green = pfru_pkg::widen5(word[9:5]);
      end
   end

   // Format select
   always_comb begin
      case (fmt)
         pfru_pkg::FMT_MONO: begin
            color = src_byte[mono_bit] ? pfru_pkg::COLOR_WHITE : '0;
         end
         pfru_pkg::FMT_GREY8: begin
            color = {src_byte, src_byte, src_byte};
         end
         pfru_pkg::FMT_RGB565, pfru_pkg::FMT_ARGB1555: begin
            color = {red, green, blue};
         end
         default: begin
            color = gathered;
         end
      endcase
   end

endmodule

### src/pfru_position.sv
// Column and row counters for the pixel format to RGB24 unpacker.
// Flags row end, picture end and row pad bytes; latches picture completion.
// Depends on pfru_pkg.
`timescale 1ns / 1ps

module pfru_position #(
   parameter int MAX_DIM = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             restart,
   input  logic                             advance,
   input  logic                             pad_enable,
   input  logic [pfru_pkg::DIM_REG_W-1:0]   row_pixels,
   input  logic [pfru_pkg::DIM_REG_W-1:0]   row_count,
   output pfru_pkg::pos_status_type         status,
   output logic                             picture_done
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = CNT_W + 1;

   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             done_ff, done_in;
   logic [DIM_W-1:0] width_eff;
   logic [DIM_W-1:0] height_eff;

   // Clamp dimensions to 1..MAX_DIM
   always_comb begin
      if (row_pixels == '0) begin
         width_eff = DIM_W'(1);
      end else if (32'(row_pixels) > MAX_DIM) begin
         width_eff = DIM_W'(MAX_DIM);
      end else begin
         width_eff = DIM_W'(row_pixels);
      end
      if (row_count == '0) begin
         height_eff = DIM_W'(1);
      end else if (32'(row_count) > MAX_DIM) begin
         height_eff = DIM_W'(MAX_DIM);
      end else begin
         height_eff = DIM_W'(row_count);
      end
   end

   // Position flags; 3*w mod 4 padding reduces to w mod 4
   always_comb begin
      status.row_end     = (DIM_W'(column_ff) + DIM_W'(1)) >= width_eff;
      status.picture_end = status.row_end && ((DIM_W'(row_ff) + DIM_W'(1)) >= height_eff);
      status.pad_bytes   = (status.row_end && pad_enable) ? width_eff[1:0] : 2'd0;
   end

   // Counter advance
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      done_in   = done_ff;
      if (restart) begin
         column_in = '0;
         row_in    = '0;
         done_in   = 1'b0;
      end else if (advance) begin
         if (status.picture_end) begin
            column_in = '0;
            row_in    = '0;
            done_in   = 1'b1;
         end else if (status.row_end) begin
            column_in = '0;
            row_in    = row_ff + CNT_W'(1);
         end else begin
            column_in = column_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         done_ff   <= 1'b0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         done_ff   <= done_in;
      end
   end

   assign picture_done = done_ff;

endmodule

### src/pixel_format_to_rgb24_unpacker_core.sv
// Top level of the pixel format to RGB24 unpacker.
// Input byte register, byte gather, output register; uses pfru_color, pfru_position, pfru_pkg.
//
//   Channel   Direction  Payload                                       Handshake
//   req_*     in         tdata[7:0] source_byte                        tvalid/tready
//   rsp_*     out        tdata pixel/pad/picture_end/last, tlast=row   tvalid/tready
//   csr_*     in         wr_en, index[1:0], wdata[12:0]                write enable only
//
// One request per cycle for grey8 and the multi-byte formats while the result register is
// free: the request register feeds the converter and the result register in the same cycle.
// A mono request holds the request register until it has yielded all its pixels (up to
// eight) or the picture ends. Reset is synchronous and restores the default registers
// (rgb32, 1x1, no pad). A stalled result register holds the request register, which in
// turn drops req_tready. Any csr write restarts the picture.
`timescale 1ns / 1ps

module pixel_format_to_rgb24_unpacker_core #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pfru_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] source_byte
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pfru_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [23:0] pixel_color,
                                                            // [25:24] pad_bytes,
                                                            // [26] picture_end,
                                                            // [27] last_of_run, [31:28] 0
   output logic                                rsp_tlast,   // row_end
   // Configuration
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [pfru_pkg::DIM_REG_W-1:0]      csr_wdata
);

   // Configuration registers
   pfru_pkg::pix_fmt_type               fmt_ff;
   logic [pfru_pkg::DIM_REG_W-1:0]      row_pixels_ff;
   logic [pfru_pkg::DIM_REG_W-1:0]      row_count_ff;
   logic                                pad_enable_ff;

   // Request register and per-picture state
   logic                                hold_valid_ff;
   logic [pfru_pkg::BYTE_W-1:0]         hold_byte_ff;
   logic [2:0]                          mono_bit_ff, mono_bit_in;
   logic [pfru_pkg::COLOR_W-1:0]        gather_ff, gather_in;
   logic [1:0]                          byte_pos_ff, byte_pos_in;

   // Result register
   logic                                rsp_valid_ff;
   logic [pfru_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic                                rsp_last_ff;

   logic                                restart;
   logic                                is_mono;
   logic                                is_grey;
   logic [1:0]                          last_pos;
   logic [pfru_pkg::COLOR_W-1:0]        gather_new;
   logic [pfru_pkg::COLOR_W-1:0]        color;
   logic                                emit_need;
   logic                                out_free;
   logic                                step_go;
   logic                                consume;
   logic                                last_of_run;
   logic                                picture_done;
   pfru_pkg::pos_status_type            status;

   assign restart = csr_wr_en;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff        <= pfru_pkg::FMT_RGB32;
         row_pixels_ff <= pfru_pkg::DIM_REG_W'(1);
         row_count_ff  <= pfru_pkg::DIM_REG_W'(1);
         pad_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (pfru_pkg::csr_index_type'(csr_index))
            pfru_pkg::REG_PIXEL_FORMAT: fmt_ff <= pfru_pkg::pix_fmt_type'(csr_wdata[2:0]);
            pfru_pkg::REG_ROW_PIXELS:   row_pixels_ff <= csr_wdata;
            pfru_pkg::REG_ROW_COUNT:    row_count_ff  <= csr_wdata;
            pfru_pkg::REG_PAD_ENABLE:   pad_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Format decode: byte position of the last byte in a pixel
   always_comb begin
      is_mono = (fmt_ff == pfru_pkg::FMT_MONO);
      is_grey = (fmt_ff == pfru_pkg::FMT_GREY8);
      case (fmt_ff)
         pfru_pkg::FMT_RGB565, pfru_pkg::FMT_ARGB1555: last_pos = 2'd1;
         pfru_pkg::FMT_RGB24:                          last_pos = 2'd2;
         default:                                      last_pos = 2'd3;
      endcase
   end

   // Merge the held byte into the gather word; the fourth rgb32 byte is dropped
   always_comb begin
      gather_new = gather_ff;
      case (byte_pos_ff)
         2'd0:    gather_new[7:0]   = hold_byte_ff;
         2'd1:    gather_new[15:8]  = gather_ff[15:8] | hold_byte_ff;
         2'd2:    gather_new[23:16] = gather_ff[23:16] | hold_byte_ff;
         default: gather_new = gather_ff;
      endcase
   end

   pfru_color u_color (
      .fmt      (fmt_ff),
      .src_byte (hold_byte_ff),
      .mono_bit (mono_bit_ff),
      .gathered (gather_new),
      .color    (color)
   );

   pfru_position #(
      .MAX_DIM (MAX_DIM)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .advance      (step_go && emit_need),
      .pad_enable   (pad_enable_ff),
      .row_pixels   (row_pixels_ff),
      .row_count    (row_count_ff),
      .status       (status),
      .picture_done (picture_done)
   );

   // Step control for the held request
   always_comb begin
      emit_need   = !picture_done && (is_mono || is_grey || (byte_pos_ff >= last_pos));
      out_free    = !rsp_valid_ff || rsp_tready;
      step_go     = hold_valid_ff && (!emit_need || out_free);
      last_of_run = !is_mono || (mono_bit_ff == 3'd7) || status.picture_end;
      consume     = !emit_need || last_of_run;
      req_tready  = !hold_valid_ff || (step_go && consume);
   end

   // Gather and bit position updates
   always_comb begin
      gather_in   = gather_ff;
      byte_pos_in = byte_pos_ff;
      mono_bit_in = mono_bit_ff;
      if (restart) begin
         gather_in   = '0;
         byte_pos_in = 2'd0;
         mono_bit_in = 3'd0;
      end else if (step_go && !picture_done) begin
         if (is_mono) begin
            mono_bit_in = consume ? 3'd0 : mono_bit_ff + 3'd1;
         end else if (!is_grey) begin
            if (byte_pos_ff >= last_pos) begin
               gather_in   = '0;
               byte_pos_in = 2'd0;
            end else begin
               gather_in   = gather_new;
               byte_pos_in = byte_pos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         mono_bit_ff   <= 3'd0;
         gather_ff     <= '0;
         byte_pos_ff   <= 2'd0;
      end else begin
         mono_bit_ff <= mono_bit_in;
         gather_ff   <= gather_in;
         byte_pos_ff <= byte_pos_in;
         if (req_tvalid && req_tready) begin
            hold_valid_ff <= 1'b1;
         end else if (step_go && consume) begin
            hold_valid_ff <= 1'b0;
         end
      end
   end

   // Request byte capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hold_byte_ff <= req_tdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go && emit_need) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && emit_need) begin
         rsp_data_ff <= {4'b0000, last_of_run, status.picture_end, status.pad_bytes, color};
         rsp_last_ff <= status.row_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### bench/pfru_pixel_checker.sv
// Pixel checker for the pixel format to RGB24 unpacker: watches the request, result and csr
// ports, predicts every pixel and compares it field by field. Depends on pfru_pkg.
`timescale 1ns / 1ps

module pfru_pixel_checker #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [pfru_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] source_byte
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [pfru_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [23:0] pixel_color,
                                                            // [25:24] pad_bytes,
                                                            // [26] picture_end,
                                                            // [27] last_of_run
   input  logic                                rsp_tlast,   // row_end
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [pfru_pkg::DIM_REG_W-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  pixels_pending
);

   typedef struct packed {
      logic [23:0] color;
      logic        row_end;
      logic [1:0]  pad_bytes;
      logic        picture_end;
      logic        last_of_byte;
   } pixel_type;

   // Pixels still owed by the block, oldest first
   pixel_type   pixels_due[$];
   // Pixels caused by the byte being predicted
   pixel_type   byte_pixels[8];
   int          byte_pixel_cnt;
   int          pixels_seen;

   // Shadow of the configuration and the unpacking state
   pfru_pkg::pix_fmt_type fmt_q;
   logic [12:0] row_pixels_q;
   logic [12:0] row_count_q;
   logic        pad_on_q;
   logic [23:0] gather_q;
   logic [1:0]  gather_pos_q;
   logic [11:0] col_q;
   logic [11:0] row_q;
   logic        done_q;

   // Zero means one, anything past MAX_DIM means MAX_DIM
   function automatic int clamp_dim(input logic [12:0] v);
      if (v == 13'd0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // Left-justify an n-bit field in a byte, low bits set when the result is nonzero
   function automatic logic [7:0] stretch_field(input logic [7:0] field, input int bits);
      logic [7:0] v;
      v = field << (8 - bits);
      if (v != 8'd0) v = v | (8'hff >> bits);
      return v;
   endfunction

   function automatic logic [23:0] expand_16bit(input logic [15:0] word, input logic is565);
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      blue  = stretch_field({3'd0, word[4:0]}, 5);
      green = is565 ? stretch_field({2'd0, word[10:5]}, 6)
                    : stretch_field({3'd0, word[9:5]}, 5);
      red   = stretch_field({3'd0, word[15:11]}, 5);
      return {red, green, blue};
   endfunction

   task automatic restart_picture();
      gather_q     = '0;
      gather_pos_q = '0;
      col_q        = '0;
      row_q        = '0;
      done_q       = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: pixel %0d %s mismatch: got %0h want %0h",
               $time, pixels_seen, what, got, want);
      fail_count = fail_count + 1;
   endtask

   // Append one pixel to the current byte's list and step column and row
   task automatic emit_pixel(input logic [23:0] color);
      pixel_type px;
      int     w;
      int     h;
      int     pad;
      logic   rend;
      logic   pend;
      w    = clamp_dim(row_pixels_q);
      h    = clamp_dim(row_count_q);
      rend = (int'(col_q) + 1 >= w);
      pend = rend && (int'(row_q) + 1 >= h);
      pad  = (rend && pad_on_q) ? ((4 - ((w * 3) & 3)) & 3) : 0;
      px.color        = color;
      px.row_end      = rend;
      px.pad_bytes    = pad[1:0];
      px.picture_end  = pend;
      px.last_of_byte = 1'b0;
      byte_pixels[byte_pixel_cnt] = px;
      byte_pixel_cnt = byte_pixel_cnt + 1;
      if (pend) begin
         done_q = 1'b1;
         col_q  = '0;
         row_q  = '0;
      end else if (rend) begin
         col_q = '0;
         row_q = row_q + 12'd1;
      end else begin
         col_q = col_q + 12'd1;
      end
   endtask

   task automatic predict_byte(input logic [7:0] b);
      logic [1:0]  last_pos;
      logic [23:0] color;
      byte_pixel_cnt = 0;
      if (done_q) return;
      case (fmt_q)
         pfru_pkg::FMT_MONO: begin
            // stops on the picture's last pixel, leftover bits dropped
            for (int i = 0; i < 8; i++) begin
               if (!done_q) emit_pixel(b[i] ? pfru_pkg::COLOR_WHITE : 24'd0);
            end
         end
         pfru_pkg::FMT_GREY8: begin
            emit_pixel({b, b, b});
         end
         default: begin
            case (fmt_q)
               pfru_pkg::FMT_RGB565, pfru_pkg::FMT_ARGB1555: last_pos = 2'd1;
               pfru_pkg::FMT_RGB24:                          last_pos = 2'd2;
               default:                                      last_pos = 2'd3;
            endcase
            if (gather_pos_q != 2'd3)
               gather_q = gather_q | ({16'd0, b} << (8 * gather_pos_q));
            if (gather_pos_q >= last_pos) begin
               if (last_pos == 2'd1)
                  color = expand_16bit(gather_q[15:0], fmt_q == pfru_pkg::FMT_RGB565);
               else color = gather_q;
               gather_q     = '0;
               gather_pos_q = '0;
               emit_pixel(color);
            end else begin
               gather_pos_q = gather_pos_q + 2'd1;
            end
         end
      endcase
      if (byte_pixel_cnt > 0) byte_pixels[byte_pixel_cnt-1].last_of_byte = 1'b1;
      for (int i = 0; i < byte_pixel_cnt; i++) pixels_due.push_back(byte_pixels[i]);
   endtask

   task automatic apply_csr(input pfru_pkg::csr_index_type idx, input logic [12:0] value);
      case (idx)
         pfru_pkg::REG_PIXEL_FORMAT: fmt_q        = pfru_pkg::pix_fmt_type'(value[2:0]);
         pfru_pkg::REG_ROW_PIXELS:   row_pixels_q = value;
         pfru_pkg::REG_ROW_COUNT:    row_count_q  = value;
         pfru_pkg::REG_PAD_ENABLE:   pad_on_q     = value[0];
      endcase
      restart_picture();
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (pixels_due.size() == 0) begin
         report_mismatch("unrequested pixel", rsp_tdata, 32'd0);
      end else begin
         want = pixels_due.pop_front();
         if (rsp_tdata[23:0] !== want.color)
            report_mismatch("pixel_color", 32'(rsp_tdata[23:0]), 32'(want.color));
         if (rsp_tlast !== want.row_end)
            report_mismatch("row_end", 32'(rsp_tlast), 32'(want.row_end));
         if (rsp_tdata[25:24] !== want.pad_bytes)
            report_mismatch("pad_bytes", 32'(rsp_tdata[25:24]), 32'(want.pad_bytes));
         if (rsp_tdata[26] !== want.picture_end)
            report_mismatch("picture_end", 32'(rsp_tdata[26]), 32'(want.picture_end));
         if (rsp_tdata[27] !== want.last_of_byte)
            report_mismatch("last_of_run", 32'(rsp_tdata[27]), 32'(want.last_of_byte));
      end
      pixels_seen = pixels_seen + 1;
   endtask

   // Result first: a request accepted at this edge cannot show up before the next one
   always @(posedge clock) begin
      if (reset) begin
         fmt_q        = pfru_pkg::FMT_RGB32;
         row_pixels_q = 13'd1;
         row_count_q  = 13'd1;
         pad_on_q     = 1'b0;
         restart_picture();
         pixels_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_pixel();
         if (csr_wr_en) apply_csr(pfru_pkg::csr_index_type'(csr_index), csr_wdata);
         if (req_tvalid && req_tready) predict_byte(req_tdata);
      end
      pixels_pending = pixels_due.size();
   end

endmodule

### bench/tb_pixel_format_to_rgb24_unpacker_core.sv
// Testbench top for the pixel format to RGB24 unpacker: clock, reset, csr writes, byte
// requests and result backpressure; checking sits in pfru_pixel_checker. Uses pfru_pkg.
`timescale 1ns / 1ps

module tb_pixel_format_to_rgb24_unpacker_core;

   localparam int MAX_DIM        = 4096;
   localparam int RANDOM_BYTES   = 380;
   localparam int LONG_HOLD      = 150;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [pfru_pkg::BYTE_W-1:0]          req_tdata;   // [7:0] source_byte
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;
   logic [pfru_pkg::RSP_DATA_W-1:0]      rsp_tdata;   // [23:0] pixel_color, [25:24] pad_bytes,
                                                      // [26] picture_end, [27] last_of_run
   logic                                 rsp_tlast;   // row_end
   logic                                 csr_wr_en;
   logic [1:0]                           csr_index;
   logic [pfru_pkg::DIM_REG_W-1:0]       csr_wdata;

   int fail_count;
   int pixels_pending;
   int hold_asks  = 0;
   int holds_done = 0;
   int idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pixel_format_to_rgb24_unpacker_core #(
      .MAX_DIM (MAX_DIM)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pfru_pixel_checker #(
      .MAX_DIM (MAX_DIM)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending)
   );

   // Watchdog: too long without any handshake or csr write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Idle stretch: mostly short, now and then long
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int clamp_size(input logic [12:0] v);
      if (v == 13'd0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic int bytes_for(input logic [2:0] fmt, input int pixels);
      case (pfru_pkg::pix_fmt_type'(fmt))
         pfru_pkg::FMT_MONO:                           return (pixels + 7) / 8;
         pfru_pkg::FMT_GREY8:                          return pixels;
         pfru_pkg::FMT_RGB565, pfru_pkg::FMT_ARGB1555: return 2 * pixels;
         pfru_pkg::FMT_RGB24:                          return 3 * pixels;
         default:                                      return 4 * pixels;
      endcase
   endfunction

   // Result backpressure, including the long holds asked for by the request side
   initial begin : rsp_ready_gen
      int calm_left;
      calm_left  = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (holds_done != hold_asks) begin
            holds_done = holds_done + 1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (calm_left > 0) begin
            calm_left = calm_left - 1;
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 9) < 3) begin
            rsp_tready <= 1'b0;
            repeat (idle_length()) @(posedge clock);
         end else begin
            if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 80);
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Single-cycle csr write, enable dropped in the following cycle
   task automatic write_reg(input pfru_pkg::csr_index_type idx, input logic [12:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // All four registers, in a rotated order that starts at a random register
   task automatic set_picture(input logic [12:0] fmt_word, input logic [12:0] width_word,
                              input logic [12:0] height_word, input logic pad_on);
      logic [11:0]             filler;
      int                      first;
      pfru_pkg::csr_index_type idx;
      filler = 12'($urandom);
      first  = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
         idx = pfru_pkg::csr_index_type'(2'((first + k) % 4));
         case (idx)
            pfru_pkg::REG_PIXEL_FORMAT: write_reg(idx, fmt_word);
            pfru_pkg::REG_ROW_PIXELS:   write_reg(idx, width_word);
            pfru_pkg::REG_ROW_COUNT:    write_reg(idx, height_word);
            pfru_pkg::REG_PAD_ENABLE:   write_reg(idx, {filler, pad_on});
         endcase
      end
   endtask

   // Wait for every owed pixel, then let the block finish any half-used byte
   task automatic settle();
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Offer one byte after an optional gap and wait for it to be taken
   task automatic send_byte(input logic [7:0] b, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic close_picture();
      req_tvalid <= 1'b0;
      settle();
   endtask

   task automatic send_random_bytes(input int count, input bit no_gaps);
      int gap;
      for (int i = 0; i < count; i++) begin
         gap = (no_gaps || $urandom_range(0, 9) >= 3) ? 0 : idle_length();
         send_byte(8'($urandom), gap);
      end
      close_picture();
   endtask

   // One picture of random shape; mostly complete, some cut short, some overrun
   task automatic run_random_picture(output int useful);
      logic [2:0]  fmt;
      logic [9:0]  fmt_filler;
      logic [12:0] width_word;
      logic [12:0] height_word;
      int          pick;
      int          needed;
      int          nbytes;
      bit          burst;
      bit          calm;
      if ($urandom_range(0, 9) == 0) fmt = 3'($urandom_range(6, 7));
      else fmt = 3'($urandom_range(0, 5));
      fmt_filler = 10'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 0) width_word = 13'd0;
      else if (pick == 1) width_word = 13'($urandom_range(4097, 8191));
      else if (pick == 2) width_word = 13'd4096;
      else width_word = 13'($urandom_range(1, 9));
      pick = $urandom_range(0, 19);
      if (pick == 0) height_word = 13'd0;
      else if (pick == 1) height_word = 13'($urandom_range(4097, 8191));
      else height_word = 13'($urandom_range(1, 4));
      // a burst picture runs against a long result hold
      burst = (hold_asks == 0) || ($urandom_range(0, 14) == 0);
      if (burst) begin
         width_word  = 13'd9;
         height_word = 13'd4;
      end
      calm   = ($urandom_range(0, 4) == 0);
      needed = bytes_for(fmt, clamp_size(width_word) * clamp_size(height_word));
      if (needed > 48) begin
         nbytes = $urandom_range(8, 40);
         useful = nbytes;
      end else if ($urandom_range(0, 7) == 0) begin
         nbytes = $urandom_range(1, needed);
         useful = nbytes;
      end else begin
         nbytes = needed + $urandom_range(0, 2);
         useful = needed;
      end
      set_picture({fmt_filler, fmt}, width_word, height_word, 1'($urandom_range(0, 1)));
      if (burst) hold_asks = hold_asks + 1;
      send_random_bytes(nbytes, burst || calm);
   endtask

   initial begin : stimulus
      int sent;
      int useful;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = pfru_pkg::REG_PIXEL_FORMAT;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: rgb32 1x1, then a byte past the picture end
      send_byte(8'h00, 0);
      send_byte(8'hff, 0);
      send_byte(8'h80, 0);
      send_byte(8'h7f, 0);
      send_byte(8'h55, 0);
      close_picture();

      // Mono, 3x2 padded: the byte ends the picture with two bits to spare
      set_picture({10'd0, pfru_pkg::FMT_MONO}, 13'd3, 13'd2, 1'b1);
      send_byte(8'ha5, 0);
      close_picture();

      // Grey extremes on a padded 2-pixel row
      set_picture({10'd0, pfru_pkg::FMT_GREY8}, 13'd2, 13'd1, 1'b1);
      send_byte(8'hff, 0);
      send_byte(8'h00, 1);
      close_picture();

      // 565: all ones, one-bit fields, all zeros
      set_picture({10'd0, pfru_pkg::FMT_RGB565}, 13'd3, 13'd1, 1'b0);
      send_byte(8'hff, 0);
      send_byte(8'hff, 0);
      send_byte(8'h21, 2);
      send_byte(8'h08, 0);
      send_byte(8'h00, 0);
      send_byte(8'h00, 0);
      close_picture();

      // 1555 with bit 15 and the alpha-position bit set
      set_picture({10'd0, pfru_pkg::FMT_ARGB1555}, 13'd2, 13'd1, 1'b1);
      send_byte(8'h5a, 0);
      send_byte(8'ha5, 0);
      send_byte(8'he0, 0);
      send_byte(8'h83, 0);
      close_picture();

      // rgb24, then a spare format code with zero sizes taken as 1x1
      set_picture({10'd0, pfru_pkg::FMT_RGB24}, 13'd1, 13'd1, 1'b1);
      send_byte(8'h01, 0);
      send_byte(8'h02, 0);
      send_byte(8'h03, 0);
      close_picture();
      set_picture({10'h3ff, pfru_pkg::FMT_SPARE7}, 13'd0, 13'd0, 1'b0);
      send_byte(8'h11, 0);
      send_byte(8'h22, 0);
      send_byte(8'h33, 0);
      send_byte(8'h44, 0);
      close_picture();

      // Oversized sizes clamp; only the start of the picture is sent
      set_picture({10'd0, pfru_pkg::FMT_MONO}, 13'h1fff, 13'h1fff, 1'b1);
      send_byte(8'hff, 0);
      send_byte(8'h00, 0);
      close_picture();

      // Random pictures
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         run_random_picture(useful);
         sent = sent + useful;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
src/pfru_pkg.sv
src/pfru_color.sv
src/pfru_position.sv
src/pixel_format_to_rgb24_unpacker_core.sv
bench/pfru_pixel_checker.sv
bench/tb_pixel_format_to_rgb24_unpacker_core.sv
